// ===== design/cdd_pkg.sv =====
// Shared types, constants and helper functions for the calendar day difference block.
`timescale 1ns / 1ps

package cdd_pkg;

  // Field widths of the input and result items.
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 23;

  typedef logic [DAY_W-1:0]          day_t;
  typedef logic [MONTH_W-1:0]        month_t;
  typedef logic [YEAR_W-1:0]         year_t;
  typedef logic signed [COUNT_W-1:0] day_count_t;

  // Shifted year (true year plus one) and month index inside that year.
  typedef logic [YEAR_W:0] year_shifted_t;

  typedef struct packed {
    year_shifted_t yp;
    logic [3:0]    mi;
  } lin_month_t;

  // Largest and smallest day counts a result item can carry.
  localparam int DAY_COUNT_MAX = 4194303;
  localparam int DAY_COUNT_MIN = -31;

  // floor(x / 100) equals (x * RECIP_100) >> RECIP_SHIFT for x below 2**15.
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int CENTURY     = 100;
  localparam int YEAR_DAYS   = 365;

  // Days in the year before the first day of month index mi (0 is January).
  function automatic logic [8:0] days_before_month(input logic [3:0] mi);
    logic [8:0] d;
    case (mi)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Splits a date into its linear month position. Month zero is December of
  // the year before, and months past twelve run into the next year.
  function automatic lin_month_t split_month(input year_t y, input month_t m);
    lin_month_t r;
    if (m == '0) begin
      r.yp = {1'b0, y};
      r.mi = 4'd11;
    end else if (m > 4'd12) begin
      r.yp = {1'b0, y} + 15'd2;
      r.mi = m - 4'd13;
    end else begin
      r.yp = {1'b0, y} + 15'd1;
      r.mi = m - 4'd1;
    end
    return r;
  endfunction

endpackage

// ===== design/calendar_day_difference.sv =====
// Top level: signed day count between a start date and an end date.
`timescale 1ns / 1ps

// Usage:
// An item on the input channel carries a start and an end date (day, month,
// year). It is accepted at a rising edge with in_valid high and in_stall low.
// The result channel returns one signed day count per item, accepted with
// out_valid high and out_stall low; out_day_count holds while stalled.
// Each date is turned into a day number by a sequencer around one shared
// 15 x 13 bit multiplier that computes in turn the century count of the
// year before, the century count for the leap test, the century check
// product and 365 times the year. Four multiplier passes and one
// accumulate step per date, for two dates, are followed by a final step
// that forms the result. The block returns to idle with that result and
// takes no new item before then; in_stall is high meanwhile.
// If the previous result still waits in the output register, the finished
// result holds in the block until the receiver takes the old one.
// A synchronous reset (rst_n low) returns the sequencer to idle and empties
// the output register. Totals above 4194303 saturate to that value.
module calendar_day_difference (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cdd_pkg::day_t       in_start_day,
  input  cdd_pkg::month_t     in_start_month,
  input  cdd_pkg::year_t      in_start_year,
  input  cdd_pkg::day_t       in_end_day,
  input  cdd_pkg::month_t     in_end_month,
  input  cdd_pkg::year_t      in_end_year,
  output logic                out_valid,
  input  logic                out_stall,
  output cdd_pkg::day_count_t out_day_count
);

  import cdd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULK = 3'd1;
  localparam logic [2:0] ST_MULY = 3'd2;
  localparam logic [2:0] ST_MULH = 3'd3;
  localparam logic [2:0] ST_MULD = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam int PROD_W = 28;
  localparam int ACC_W  = 25;

  // Control state.
  logic [2:0] state_r, state_nxt;
  logic       sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Latched item and working registers.
  day_t              sd_r, ed_r;
  month_t            sm_r, em_r;
  year_t             sy_r, ey_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [7:0]        c100_r, c100_nxt;
  logic              leap_r, leap_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  day_count_t        out_count_r, out_count_nxt;

  // Date under work and its derived terms.
  lin_month_t    cur_lm, start_lm, end_lm;
  year_shifted_t k_val, yv_val;
  logic          yp_ge1, yp_ge2;
  logic [14:0]   mul_a;
  logic [12:0]   mul_b;
  logic [7:0]    prod_q;
  logic [14:0]   yr_term;
  logic [23:0]   day_num;
  logic          months_pos;
  logic signed [ACC_W-1:0] ddiff, total;

  assign start_lm = split_month(sy_r, sm_r);
  assign end_lm   = split_month(ey_r, em_r);
  assign cur_lm   = sel_r ? end_lm : start_lm;

  assign yp_ge1 = (cur_lm.yp >= 15'd1);
  assign yp_ge2 = (cur_lm.yp >= 15'd2);
  assign k_val  = yp_ge2 ? cur_lm.yp - 15'd2 : '0;
  assign yv_val = yp_ge1 ? cur_lm.yp - 15'd1 : '0;

  // Quotient by 100 taken from the reciprocal product.
  assign prod_q = prod_r[RECIP_SHIFT+7:RECIP_SHIFT];

  // Leap days of whole years before this one, counted from year zero.
  assign yr_term = yp_ge2
                 ? {2'b00, k_val[14:2]} - {7'b0, c100_r} + {9'b0, c100_r[7:2]} + 15'd1
                 : '0;

  // Day number of the first day of the current linear month.
  assign day_num = prod_r[23:0] + 24'(yr_term) + 24'(days_before_month(cur_lm.mi))
                 + 24'((cur_lm.mi >= 4'd2) && leap_r);

  // End month strictly after start month in the linear month sequence.
  assign months_pos = (end_lm.yp > start_lm.yp)
                   || ((end_lm.yp == start_lm.yp) && (end_lm.mi > start_lm.mi));

  assign ddiff = $signed(ACC_W'(ed_r)) - $signed(ACC_W'(sd_r));
  assign total = (months_pos ? acc_r : '0) + ddiff;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MULK: begin
        mul_a = k_val;
        mul_b = 13'(RECIP_100);
      end
      ST_MULY: begin
        mul_a = yv_val;
        mul_b = 13'(RECIP_100);
      end
      ST_MULH: begin
        mul_a = {7'b0, prod_q};
        mul_b = 13'(CENTURY);
      end
      ST_MULD: begin
        mul_a = cur_lm.yp;
        mul_b = 13'(YEAR_DAYS);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    prod_nxt      = PROD_W'(mul_a) * PROD_W'(mul_b);
    c100_nxt      = c100_r;
    leap_nxt      = leap_r;
    acc_nxt       = acc_r;
    out_count_nxt = out_count_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MULK;
          sel_nxt   = 1'b0;
          acc_nxt   = '0;
        end
      end
      ST_MULK: begin
        state_nxt = ST_MULY;
      end
      ST_MULY: begin
        c100_nxt  = prod_q;
        state_nxt = ST_MULH;
      end
      ST_MULH: begin
        // The leap test needs the low bits of the year and its century count.
        leap_nxt  = yp_ge1 && (yv_val[1:0] == 2'b00) && (prod_q[1:0] == 2'b00);
        state_nxt = ST_MULD;
      end
      ST_MULD: begin
        // A year divisible by 4 but not by 100 is a leap year too.
        if (yp_ge1 && (yv_val[1:0] == 2'b00) && (yv_val != prod_r[14:0])) begin
          leap_nxt = 1'b1;
        end
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (sel_r) begin
          acc_nxt   = acc_r + $signed({1'b0, day_num});
          state_nxt = ST_DONE;
        end else begin
          acc_nxt   = acc_r - $signed({1'b0, day_num});
          sel_nxt   = 1'b1;
          state_nxt = ST_MULK;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_count_nxt = (total > ACC_W'(DAY_COUNT_MAX))
                        ? day_count_t'(DAY_COUNT_MAX) : total[COUNT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      sd_r <= in_start_day;
      sm_r <= in_start_month;
      sy_r <= in_start_year;
      ed_r <= in_end_day;
      em_r <= in_end_month;
      ey_r <= in_end_year;
    end
    prod_r      <= prod_nxt;
    c100_r      <= c100_nxt;
    leap_r      <= leap_nxt;
    acc_r       <= acc_nxt;
    out_count_r <= out_count_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_day_count = out_count_r;

endmodule

// ===== design/cdd_checker.sv =====
// Port-level checker for the calendar day difference block and its bind.
`timescale 1ns / 1ps

module cdd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input cdd_pkg::day_count_t out_day_count
);

  import cdd_pkg::*;

  // An accepted item keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took no time on an accepted item");

  // A new result only appears after the block was busy with an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  // A shown result never falls below the smallest possible day count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_day_count >= day_count_t'(DAY_COUNT_MIN)))
    else $error("day count below the smallest possible value");

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_day_count)))
    else $error("stalled result changed");

endmodule

bind calendar_day_difference cdd_checker u_cdd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_day_count (out_day_count)
);
